@@ hdl/wsp_pkg.sv @@
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants for the wheel speed median block: payload
// structs of the sample and result channels, configuration layout, widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsp_pkg;

  localparam int WHEELS          = 4;
  localparam int COUNT_OUT_BITS  = 16;
  localparam int SPEED_BITS      = 24;
  localparam int WINDOW_BITS     = 24;
  localparam int SCALE_BITS      = 16;
  localparam int CFG_DATA_BITS   = 24;
  localparam int CFG_INDEX_BITS  = 1;
  // product of the widest count and the scale, zero extended
  localparam int PROD_EXT_BITS   = 48;

  // wheel order inside vectors
  localparam int WHEEL_FL = 0;
  localparam int WHEEL_FR = 1;
  localparam int WHEEL_RL = 2;
  localparam int WHEEL_RR = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SAMPLES = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPEED_SCALE    = 1'd1;

  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 24'd1000000;
  localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = 16'd8062;

  typedef struct packed {
    logic pin_front_left;
    logic pin_front_right;
    logic pin_rear_left;
    logic pin_rear_right;
  } sample_t;

  typedef struct packed {
    logic [COUNT_OUT_BITS-1:0] count_front_left;
    logic [COUNT_OUT_BITS-1:0] count_front_right;
    logic [COUNT_OUT_BITS-1:0] count_rear_left;
    logic [COUNT_OUT_BITS-1:0] count_rear_right;
    logic [SPEED_BITS-1:0]     speed_front_left;
    logic [SPEED_BITS-1:0]     speed_front_right;
    logic [SPEED_BITS-1:0]     speed_rear_left;
    logic [SPEED_BITS-1:0]     speed_rear_right;
    logic [SPEED_BITS-1:0]     speed_median;
  } result_t;

  typedef struct packed {
    logic [WINDOW_BITS-1:0] window_samples;
    logic [SCALE_BITS-1:0]  speed_scale;
  } cfg_t;

  typedef logic [WHEELS-1:0][COUNT_OUT_BITS-1:0] count_out_vec_t;
  typedef logic [WHEELS-1:0][SPEED_BITS-1:0]     speed_vec_t;

endpackage

@@ hdl/wheel_speed_pulse_median.sv @@
// ----------------------------------------------------------------------------
// wheel_speed_pulse_median
// Result path: the sample that closes a window loads the snapshot register,
//   then the scale and median registers, each of which holds under a stall.
// Throughput: one sample per cycle; sample_stall rises only while the
//   snapshot register holds a result that the full pipeline cannot move.
// Reset: clears counters, pipeline valids and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wheel_speed_pulse_median #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [wsp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [wsp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  wsp_pkg::sample_t                      sample,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output wsp_pkg::result_t                      result
);
  import wsp_pkg::*;

  cfg_t                               cfg;
  logic                               accept;
  logic                               snap_valid;
  logic [WHEELS-1:0][COUNT_BITS-1:0]  snap_counts;
  logic                               scale_ready;
  logic                               scale_valid;
  count_out_vec_t                     scale_counts;
  speed_vec_t                         scale_speeds;
  logic                               median_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_samples <= WINDOW_RESET;
      cfg.speed_scale    <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_SAMPLES: cfg.window_samples <= cfg_data[WINDOW_BITS-1:0];
        REG_SPEED_SCALE:    cfg.speed_scale    <= cfg_data[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stall only when the snapshot is full and cannot move on
  assign sample_stall = snap_valid && !scale_ready;
  assign accept       = sample_valid && !sample_stall;

  wsp_counter #(.COUNT_BITS(COUNT_BITS)) u_counter (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .sample      (sample),
    .take        (scale_ready),
    .snap_valid  (snap_valid),
    .snap_counts (snap_counts)
  );

  wsp_scale #(.COUNT_BITS(COUNT_BITS)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (snap_valid),
    .in_counts (snap_counts),
    .ready     (scale_ready),
    .take      (median_ready),
    .valid     (scale_valid),
    .counts    (scale_counts),
    .speeds    (scale_speeds)
  );

  wsp_median u_median (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (scale_valid),
    .in_counts    (scale_counts),
    .in_speeds    (scale_speeds),
    .ready        (median_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ hdl/wsp_counter.sv @@
// ----------------------------------------------------------------------------
// wsp_counter
// Falling edge counters per wheel and the window sample counter. On the
// sample that closes a window the counts are copied into a snapshot register
// and the counters restart from zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsp_counter #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  wsp_pkg::cfg_t                             cfg,
  input  logic                                      accept,
  input  wsp_pkg::sample_t                          sample,
  input  logic                                      take,
  output logic                                      snap_valid,
  output logic [wsp_pkg::WHEELS-1:0][COUNT_BITS-1:0] snap_counts
);
  import wsp_pkg::*;

  logic [WHEELS-1:0]                  prev_levels;
  logic [WHEELS-1:0][COUNT_BITS-1:0]  counts;
  logic [WHEELS-1:0][COUNT_BITS-1:0]  counts_next;
  logic [WINDOW_BITS-1:0]             sample_count;
  logic [WINDOW_BITS-1:0]             sample_count_next;
  logic [WHEELS-1:0]                  now_levels;
  logic                               close;

  assign now_levels = {sample.pin_rear_right, sample.pin_rear_left,
                       sample.pin_front_right, sample.pin_front_left};

  // add one on a falling edge, hold when full
  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      if (prev_levels[w] && !now_levels[w] && (counts[w] != {COUNT_BITS{1'b1}})) begin
        counts_next[w] = counts[w] + COUNT_BITS'(1);
      end else begin
        counts_next[w] = counts[w];
      end
    end
  end

  assign sample_count_next = sample_count + WINDOW_BITS'(1);
  assign close             = (sample_count_next >= cfg.window_samples);

  // advance window state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels  <= '0;
      counts       <= '0;
      sample_count <= '0;
    end else if (accept) begin
      prev_levels <= now_levels;
      if (close) begin
        counts       <= '0;
        sample_count <= '0;
      end else begin
        counts       <= counts_next;
        sample_count <= sample_count_next;
      end
    end
  end

  // snapshot register: load on window close, drop when taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && close) begin
      snap_valid <= 1'b1;
    end else if (take) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && close) begin
      snap_counts <= counts_next;
    end
  end

  a_close_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && close |=> (sample_count == '0) && (counts == '0) && snap_valid)
    else $error("window close did not restart counters");

  a_snap_held: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !take |=> snap_valid && $stable(snap_counts))
    else $error("snapshot lost before it was taken");

  a_no_spurious_snap: assert property (@(posedge clk) disable iff (rst)
    !(accept && close) && !snap_valid |=> !snap_valid)
    else $error("snapshot appeared without a window close");

endmodule

@@ hdl/wsp_scale.sv @@
// ----------------------------------------------------------------------------
// wsp_scale
// Multiply each wheel count by the speed scale, drop eight fraction bits and
// saturate to the speed width. Counts are saturated to the output width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsp_scale #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  wsp_pkg::cfg_t                              cfg,
  input  logic                                       in_valid,
  input  logic [wsp_pkg::WHEELS-1:0][COUNT_BITS-1:0] in_counts,
  output logic                                       ready,
  input  logic                                       take,
  output logic                                       valid,
  output wsp_pkg::count_out_vec_t                    counts,
  output wsp_pkg::speed_vec_t                        speeds
);
  import wsp_pkg::*;

  localparam int PROD_BITS = COUNT_BITS + SCALE_BITS;

  count_out_vec_t counts_next;
  speed_vec_t     speeds_next;

  // per wheel scale and saturate
  for (genvar w = 0; w < WHEELS; w++) begin : g_wheel
    logic [PROD_BITS-1:0]     prod;
    logic [PROD_EXT_BITS-1:0] prod_ext;
    logic [31:0]              count_ext;

    assign prod      = PROD_BITS'(in_counts[w]) * PROD_BITS'(cfg.speed_scale);
    assign prod_ext  = PROD_EXT_BITS'(prod);
    assign count_ext = 32'(in_counts[w]);

    assign speeds_next[w] = (|prod_ext[PROD_EXT_BITS-1:SPEED_BITS+8]) ?
                            {SPEED_BITS{1'b1}} : prod_ext[SPEED_BITS+7:8];
    assign counts_next[w] = (|count_ext[31:COUNT_OUT_BITS]) ?
                            {COUNT_OUT_BITS{1'b1}} : count_ext[COUNT_OUT_BITS-1:0];
  end

  assign ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      counts <= counts_next;
      speeds <= speeds_next;
    end
  end

endmodule

@@ hdl/wsp_median.sv @@
// ----------------------------------------------------------------------------
// wsp_median
// Mean of the two middle wheel speeds: the larger of the pair minimums and
// the smaller of the pair maximums, added and halved. Holds the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsp_median (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  wsp_pkg::count_out_vec_t in_counts,
  input  wsp_pkg::speed_vec_t     in_speeds,
  output logic                    ready,
  output logic                    result_valid,
  input  logic                    result_stall,
  output wsp_pkg::result_t        result
);
  import wsp_pkg::*;

  logic [SPEED_BITS-1:0] lo_a, hi_a, lo_b, hi_b, mid_lo, mid_hi;
  logic [SPEED_BITS:0]   mid_sum;
  result_t               result_next;

  // sort the two pairs, then pick the middle two
  always_comb begin
    lo_a    = (in_speeds[WHEEL_FL] < in_speeds[WHEEL_FR]) ? in_speeds[WHEEL_FL] : in_speeds[WHEEL_FR];
    hi_a    = (in_speeds[WHEEL_FL] < in_speeds[WHEEL_FR]) ? in_speeds[WHEEL_FR] : in_speeds[WHEEL_FL];
    lo_b    = (in_speeds[WHEEL_RL] < in_speeds[WHEEL_RR]) ? in_speeds[WHEEL_RL] : in_speeds[WHEEL_RR];
    hi_b    = (in_speeds[WHEEL_RL] < in_speeds[WHEEL_RR]) ? in_speeds[WHEEL_RR] : in_speeds[WHEEL_RL];
    mid_lo  = (lo_a > lo_b) ? lo_a : lo_b;
    mid_hi  = (hi_a < hi_b) ? hi_a : hi_b;
    mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};
  end

  always_comb begin
    result_next.count_front_left  = in_counts[WHEEL_FL];
    result_next.count_front_right = in_counts[WHEEL_FR];
    result_next.count_rear_left   = in_counts[WHEEL_RL];
    result_next.count_rear_right  = in_counts[WHEEL_RR];
    result_next.speed_front_left  = in_speeds[WHEEL_FL];
    result_next.speed_front_right = in_speeds[WHEEL_FR];
    result_next.speed_rear_left   = in_speeds[WHEEL_RL];
    result_next.speed_rear_right  = in_speeds[WHEEL_RR];
    result_next.speed_median      = mid_sum[SPEED_BITS:1];
  end

  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      result <= result_next;
    end
  end

endmodule
